FILE: rtl/egs_pkg.sv
// Shared types and constants for the elevator group scheduler.
`default_nettype none
package egs_pkg;
    localparam int LIST_DEPTH = 32;
    localparam int LIST_AW    = 5;

    typedef enum logic [1:0] {
        FUNC_HALL = 2'd0,
        FUNC_CAR  = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        DIR_UP   = 2'd0,
        DIR_DOWN = 2'd1,
        DIR_IDLE = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOCAR  = 2'd1,
        ST_DROP   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        STRAT_SCAN = 2'd0,
        STRAT_FCFS = 2'd1,
        STRAT_LOOK = 2'd2
    } t_strat;

    localparam logic REG_STRATEGY = 1'b0;
    localparam logic REG_CARS     = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEDUP,
        S_DEDUP_W,
        S_ADD,
        S_TSTART,
        S_HEAD_W,
        S_SCANL,
        S_SCANL_W,
        S_PICK,
        S_COMPACT,
        S_COMPACT_W,
        S_EMIT,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/elevator_group_scheduler.sv
// Top level: request memory, per-car state and the walking sequencer.
//
//  channel | dir | handshake            | payload
//  s_axis  | in  | s_axis_tvalid/tready | tdata {hall_dir,floor,car,func}
//  m_axis  | out | m_axis_tvalid/tready | tdata, tlast
//  cfg     | in  | i_cfg_valid/o_cfg_ready | index, data
//
// A call walks the car's list once, reading each entry and then checking it.
// A tick walks each present car's list twice (selection, then compaction),
// and skips the walk for an empty car. The single request memory port with
// its registered read sets the pace of these walks. Reset is synchronous and
// needs no clearing pass. Input is held off while an item is in work; a
// stalled result holds the sequencer in place.
`default_nettype none
module elevator_group_scheduler
    import egs_pkg::*;
#(
    parameter int NUM_CARS = 4,
    parameter int FLOORS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] func, [3:2] car, [8:4] floor, [9] hall_dir
    input  wire logic [15:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] car_id, [3:2] status, [8:4] car_floor, [10:9] car_dir,
    // [11] car_moving, [12] arrived, [18:13] pending
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [2:0]  i_cfg_data
);
    localparam int CW = 2;
    localparam int NC = (NUM_CARS > 4) ? 4 : NUM_CARS;
    // a 5-bit floor never exceeds 31
    localparam int FL = (FLOORS > 31) ? 31 : FLOORS;

    logic [1:0] r_strategy;
    logic [2:0] r_cars;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= STRAT_SCAN;
            r_cars     <= 3'd3;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_STRATEGY) r_strategy <= i_cfg_data[1:0];
            else r_cars <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    logic [2:0] w_present;
    always_comb begin
        w_present = r_cars;
        if (w_present < 3'd1) w_present = 3'd1;
        if (w_present > 3'(NC)) w_present = 3'(NC);
    end

    // per-car state
    logic [4:0] r_floor [4];
    t_dir       r_dir   [4];
    logic [3:0] r_mov;
    logic [5:0] r_cnt   [4];

    // request memory: {down, is_car, floor}
    logic [6:0] r_mem [4*LIST_DEPTH];
    logic [6:0] r_rd;
    logic       n_we;
    logic [6:0] n_wd;
    logic [6:0] n_wa, n_ra;
    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_wa] <= n_wd;
        r_rd <= r_mem[n_ra];
    end

    t_state     r_st, n_st;
    t_func      r_func;
    logic [CW-1:0] r_car;
    logic [4:0] r_f;
    logic       r_hd;
    logic [5:0] r_i, r_k;
    logic       r_found, r_have_up, r_have_dn, r_arr;
    logic [4:0] r_upmin, r_dnmax, r_prim, r_nxt;
    t_status    r_status;
    logic       r_lastres;

    // shared compare unit: current entry against car floor
    logic [4:0] w_cur;
    logic [4:0] w_ef;
    assign w_cur = r_floor[r_car];
    assign w_ef  = r_rd[4:0];

    logic [4:0] w_inf;
    always_comb begin
        w_inf = s_axis_tdata[8:4];
        if (w_inf < 5'd1) w_inf = 5'd1;
        if (w_inf > 5'(FL)) w_inf = 5'(FL);
    end

    logic w_up;
    assign w_up = r_prim > w_cur;

    always_comb begin
        n_st = r_st;
        n_we = 1'b0;
        n_wd = r_rd;
        n_wa = {r_car, r_k[LIST_AW-1:0]};
        n_ra = {r_car, r_i[LIST_AW-1:0]};
        case (r_st)
            S_IDLE:      if (s_axis_tvalid) begin
                if (t_func'(s_axis_tdata[1:0]) == FUNC_TICK) n_st = S_TSTART;
                else if (t_func'(s_axis_tdata[1:0]) != FUNC_NONE) begin
                    if ({1'b0, s_axis_tdata[3:2]} >= w_present) n_st = S_EMIT;
                    else n_st = S_DEDUP;
                end
            end
            S_DEDUP:     n_st = (r_i >= r_cnt[r_car]) ? S_ADD : S_DEDUP_W;
            S_DEDUP_W:   n_st = S_DEDUP;
            S_ADD: begin
                n_wa = {r_car, r_cnt[r_car][LIST_AW-1:0]};
                n_wd = {(r_func == FUNC_CAR) ? !(r_f > w_cur) : r_hd,
                        r_func == FUNC_CAR, r_f};
                n_we = !r_found && r_cnt[r_car] < 6'(LIST_DEPTH);
                n_st = S_EMIT;
            end
            S_TSTART: begin
                // fetch the head entry of this car
                n_ra = {r_car, {LIST_AW{1'b0}}};
                n_st = (r_cnt[r_car] == 6'd0) ? S_EMIT : S_HEAD_W;
            end
            S_HEAD_W:    n_st = S_SCANL;
            S_SCANL:     n_st = (r_i >= r_cnt[r_car]) ? S_PICK : S_SCANL_W;
            S_SCANL_W:   n_st = S_SCANL;
            S_PICK:      n_st = S_COMPACT;
            S_COMPACT: begin
                if (r_i >= r_cnt[r_car]) n_st = S_EMIT;
                else n_st = S_COMPACT_W;
            end
            S_COMPACT_W: begin
                n_we = w_ef != r_nxt;
                n_st = S_COMPACT;
            end
            S_EMIT:      n_st = S_OUT;
            S_OUT:       if (m_axis_tready) begin
                if (r_func == FUNC_TICK && !r_lastres) n_st = S_TSTART;
                else n_st = S_IDLE;
            end
            default:     n_st = S_IDLE;
        endcase
    end

    logic [4:0] w_pick;
    t_dir       w_pdir;
    always_comb begin
        w_pick = r_prim;
        w_pdir = r_dir[r_car];
        case (r_strategy)
            STRAT_FCFS: begin
                w_pick = r_prim;
                if (r_prim != w_cur) begin
                    if (r_dir[r_car] == DIR_IDLE)
                        w_pdir = (r_prim > w_cur) ? DIR_UP : DIR_DOWN;
                    else if (r_dir[r_car] == DIR_UP && r_prim < w_cur) w_pdir = DIR_DOWN;
                    else if (r_prim > w_cur) w_pdir = DIR_UP;
                end
            end
            STRAT_LOOK: w_pick = r_have_up ? r_upmin : r_prim;
            default: begin
                if (r_dir[r_car] == DIR_IDLE) begin
                    if (!r_have_up) begin w_pdir = DIR_DOWN; w_pick = r_dnmax; end
                    else if (!r_have_dn) begin w_pdir = DIR_UP; w_pick = r_upmin; end
                    else if ((r_upmin - w_cur) < (w_cur - r_dnmax)) begin
                        w_pdir = DIR_UP; w_pick = r_upmin;
                    end else begin w_pdir = DIR_DOWN; w_pick = r_dnmax; end
                end else if (r_dir[r_car] == DIR_UP) begin
                    if (r_have_up) w_pick = r_upmin;
                    else begin w_pdir = DIR_DOWN; w_pick = r_dnmax; end
                end else begin
                    if (r_have_dn) w_pick = r_dnmax;
                    else begin w_pdir = DIR_UP; w_pick = r_upmin; end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            for (int c = 0; c < 4; c++) begin
                r_floor[c] <= 5'd1;
                r_dir[c]   <= DIR_IDLE;
                r_cnt[c]   <= 6'd0;
            end
            r_mov <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                S_IDLE: if (s_axis_tvalid) begin
                    r_func   <= t_func'(s_axis_tdata[1:0]);
                    r_car    <= (t_func'(s_axis_tdata[1:0]) == FUNC_TICK) ? '0
                                : s_axis_tdata[3:2];
                    r_f      <= w_inf;
                    r_hd     <= s_axis_tdata[9];
                    r_i      <= '0;
                    r_found  <= 1'b0;
                    r_status <= ({1'b0, s_axis_tdata[3:2]} >= w_present) ? ST_NOCAR : ST_OK;
                end
                S_DEDUP:   if (r_i < r_cnt[r_car]) r_i <= r_i + 6'd1;
                S_DEDUP_W: if (w_ef == r_f && r_rd[5] == (r_func == FUNC_CAR)) r_found <= 1'b1;
                S_ADD: begin
                    if (n_we) r_cnt[r_car] <= r_cnt[r_car] + 6'd1;
                    else r_status <= ST_DROP;
                    if (!r_mov[r_car] && (n_we || r_cnt[r_car] != 6'd0)) begin
                        if (r_f > w_cur) r_dir[r_car] <= DIR_UP;
                        else if (r_f < w_cur) r_dir[r_car] <= DIR_DOWN;
                        r_mov[r_car] <= 1'b1;
                    end
                end
                S_TSTART: begin
                    r_i <= '0; r_k <= '0; r_arr <= 1'b0;
                    r_have_up <= 1'b0; r_have_dn <= 1'b0;
                    r_status <= ST_OK;
                end
                S_HEAD_W: r_prim <= w_ef;
                S_SCANL:  if (r_i < r_cnt[r_car]) r_i <= r_i + 6'd1;
                S_SCANL_W: begin
                    if (r_strategy == STRAT_LOOK) begin
                        // up side reuses upmin; down side keeps the highest
                        if (w_up && w_ef > w_cur && w_ef <= r_prim && (r_rd[5] || !r_rd[6])) begin
                            if (!r_have_up || w_ef < r_upmin) r_upmin <= w_ef;
                            r_have_up <= 1'b1;
                        end else if (!w_up && w_ef < w_cur && w_ef >= r_prim
                                     && (r_rd[5] || r_rd[6])) begin
                            if (!r_have_up || w_ef > r_upmin) r_upmin <= w_ef;
                            r_have_up <= 1'b1;
                        end
                    end else if (w_ef > w_cur) begin
                        if (!r_have_up || w_ef < r_upmin) r_upmin <= w_ef;
                        r_have_up <= 1'b1;
                    end else begin
                        if (!r_have_dn || w_ef > r_dnmax) r_dnmax <= w_ef;
                        r_have_dn <= 1'b1;
                    end
                end
                S_PICK: begin
                    r_nxt <= ((r_strategy == STRAT_LOOK) && r_prim == w_cur) ? w_cur : w_pick;
                    if (((r_strategy == STRAT_LOOK) && r_prim == w_cur)) r_dir[r_car] <= r_dir[r_car];
                    else if (w_pick > w_cur) r_dir[r_car] <= DIR_UP;
                    else if (w_pick < w_cur) r_dir[r_car] <= DIR_DOWN;
                    else r_dir[r_car] <= w_pdir;
                    r_i <= '0;
                    r_arr <= 1'b1;
                end
                S_COMPACT: begin
                    if (r_i < r_cnt[r_car]) r_i <= r_i + 6'd1;
                    else begin
                        r_floor[r_car] <= r_nxt;
                        r_cnt[r_car]   <= r_k;
                        if (r_k == 6'd0) begin
                            r_dir[r_car] <= DIR_IDLE;
                            r_mov[r_car] <= 1'b0;
                        end else r_mov[r_car] <= 1'b1;
                    end
                end
                S_COMPACT_W: if (w_ef != r_nxt) r_k <= r_k + 6'd1;
                S_EMIT: r_lastres <= (r_func != FUNC_TICK) || ({1'b0, r_car} + 3'd1 >= w_present);
                S_OUT: if (m_axis_tready && r_func == FUNC_TICK && !r_lastres)
                    r_car <= r_car + 2'd1;
                default: ;
            endcase
        end
    end

    logic w_valid;
    assign w_valid = r_status != ST_NOCAR;
    assign s_axis_tready = r_st == S_IDLE;
    assign m_axis_tvalid = r_st == S_OUT;
    assign m_axis_tlast  = r_lastres;
    assign m_axis_tdata  = {5'd0,
                            w_valid ? r_cnt[r_car] : 6'd0,
                            w_valid && r_func == FUNC_TICK && r_arr,
                            w_valid && r_mov[r_car],
                            w_valid ? r_dir[r_car] : DIR_UP,
                            w_valid ? w_cur : 5'd0,
                            r_status,
                            r_car};
endmodule
`default_nettype wire

FILE: verif/elevator_group_scheduler_test.sv
// Self-checking stream testbench for the elevator group scheduler.
`timescale 1ns / 1ps
module elevator_group_scheduler_test;
    import egs_pkg::*;

    localparam int CARS = 4;
    localparam int TOP_FLOOR = 16;
    localparam int DEPTH = 32;
    localparam int LIMIT = 2000000;
    localparam int LONG_HOLD = 600;

    typedef struct packed {
        logic [1:0] car_id;
        logic [1:0] status;
        logic [4:0] car_floor;
        logic [1:0] car_dir;
        logic       car_moving;
        logic       arrived;
        logic [5:0] pending;
        logic       last;
    } t_report;

    typedef struct packed {
        logic [4:0] flr;
        logic       is_car;
        logic       down;
    } t_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [2:0]  i_cfg_data = '0;

    elevator_group_scheduler dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_strat      strat_m;
    logic [2:0]  cars_m;
    logic [4:0]  at_floor [CARS];
    t_dir        heading [CARS];
    logic        moving [CARS];
    t_entry      calls [CARS][DEPTH];
    int          call_cnt [CARS];

    logic [15:0] call_queue [$];
    t_report     expected_reports [$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;
    bit  hold_req = 1'b0;
    bit  in_fire = 1'b0;
    int  errors = 0;
    int  cycles = 0;

    task automatic report_error(input string what);
        errors++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    task automatic enqueue(input logic [15:0] d);
        call_queue.insert(call_queue.size(), d);
    endtask

    function automatic int present_cars();
        int n;
        n = cars_m;
        if (n < 1) n = 1;
        if (n > CARS) n = CARS;
        return n;
    endfunction

    function automatic logic [4:0] choose_scan(int c);
        logic [4:0] cur, up_min, dn_max, f;
        bit have_up, have_dn;
        cur = at_floor[c]; up_min = 0; dn_max = 0; have_up = 0; have_dn = 0;
        for (int i = 0; i < call_cnt[c]; i++) begin
            f = calls[c][i].flr;
            if (f > cur) begin
                if (!have_up || f < up_min) up_min = f;
                have_up = 1;
            end else begin
                if (!have_dn || f > dn_max) dn_max = f;
                have_dn = 1;
            end
        end
        if (heading[c] == DIR_IDLE) begin
            if (!have_up) begin heading[c] = DIR_DOWN; return dn_max; end
            if (!have_dn) begin heading[c] = DIR_UP; return up_min; end
            if (up_min - cur < cur - dn_max) begin heading[c] = DIR_UP; return up_min; end
            heading[c] = DIR_DOWN;
            return dn_max;
        end
        if (heading[c] == DIR_UP) begin
            if (have_up) return up_min;
            heading[c] = DIR_DOWN;
            return dn_max;
        end
        if (have_dn) return dn_max;
        heading[c] = DIR_UP;
        return up_min;
    endfunction

    function automatic logic [4:0] choose_fcfs(int c);
        logic [4:0] cur, nxt;
        cur = at_floor[c]; nxt = calls[c][0].flr;
        if (nxt == cur) return cur;
        if (heading[c] == DIR_IDLE) heading[c] = nxt > cur ? DIR_UP : DIR_DOWN;
        else if (heading[c] == DIR_UP && nxt < cur) heading[c] = DIR_DOWN;
        else if (nxt > cur) heading[c] = DIR_UP;
        return nxt;
    endfunction

    function automatic logic [4:0] choose_look(int c);
        logic [4:0] cur, prim, best, f;
        bit have, up;
        t_entry e;
        cur = at_floor[c]; prim = calls[c][0].flr; best = 0; have = 0;
        if (prim == cur) return cur;
        up = prim > cur;
        for (int i = 0; i < call_cnt[c]; i++) begin
            e = calls[c][i]; f = e.flr;
            if (up && f > cur && f <= prim && (e.is_car || !e.down)) begin
                if (!have || f < best) best = f;
                have = 1;
            end else if (!up && f < cur && f >= prim && (e.is_car || e.down)) begin
                if (!have || f > best) best = f;
                have = 1;
            end
        end
        return have ? best : prim;
    endfunction

    function automatic t_report car_report(int c, t_status st, logic arr);
        t_report r;
        r.car_id = c[1:0]; r.status = st; r.car_floor = at_floor[c];
        r.car_dir = heading[c]; r.car_moving = moving[c]; r.arrived = arr;
        r.pending = call_cnt[c][5:0]; r.last = 1'b0;
        return r;
    endfunction

    // Advance the predictor by one request and queue the reports it causes.
    task automatic predict_request(input logic [15:0] d);
        t_func fn;
        int car, flr, n, k;
        bit down, found, arr;
        logic [4:0] nxt;
        t_status st;
        t_report r;
        t_entry e;
        fn = t_func'(d[1:0]); car = d[3:2]; flr = d[8:4]; down = d[9];
        n = present_cars();
        if (fn == FUNC_TICK) begin
            for (int c = 0; c < n; c++) begin
                arr = 0;
                if (call_cnt[c] != 0) begin
                    arr = 1;
                    if (strat_m == STRAT_FCFS) nxt = choose_fcfs(c);
                    else if (strat_m == STRAT_LOOK) nxt = choose_look(c);
                    else nxt = choose_scan(c);
                    if (nxt > at_floor[c]) heading[c] = DIR_UP;
                    else if (nxt < at_floor[c]) heading[c] = DIR_DOWN;
                    at_floor[c] = nxt;
                    k = 0;
                    for (int i = 0; i < call_cnt[c]; i++)
                        if (calls[c][i].flr != nxt) calls[c][k++] = calls[c][i];
                    call_cnt[c] = k;
                    if (k == 0) begin
                        heading[c] = DIR_IDLE; moving[c] = 0;
                    end else begin
                        moving[c] = 1;
                    end
                end
                r = car_report(c, ST_OK, arr);
                r.last = (c == n - 1);
                expected_reports.insert(expected_reports.size(), r);
            end
        end else if (fn != FUNC_NONE) begin
            if (flr < 1) flr = 1;
            if (flr > TOP_FLOOR) flr = TOP_FLOOR;
            if (car >= n) begin
                r = '0; r.car_id = car[1:0]; r.status = ST_NOCAR;
            end else begin
                found = 0;
                for (int i = 0; i < call_cnt[car]; i++)
                    if (calls[car][i].flr == flr[4:0] && calls[car][i].is_car == (fn == FUNC_CAR))
                        found = 1;
                st = ST_OK;
                if (found || call_cnt[car] >= DEPTH) begin
                    st = ST_DROP;
                end else begin
                    e.flr = flr[4:0]; e.is_car = (fn == FUNC_CAR);
                    e.down = e.is_car ? !(flr[4:0] > at_floor[car]) : down;
                    calls[car][call_cnt[car]] = e;
                    call_cnt[car]++;
                end
                if (!moving[car] && call_cnt[car] > 0) begin
                    if (flr[4:0] > at_floor[car]) heading[car] = DIR_UP;
                    else if (flr[4:0] < at_floor[car]) heading[car] = DIR_DOWN;
                    moving[car] = 1;
                end
                r = car_report(car, st, 1'b0);
            end
            r.last = 1'b1;
            expected_reports.insert(expected_reports.size(), r);
        end
    endtask

    // remember whether the offered request was taken at the last rising edge
    always @(posedge i_clk) in_fire <= s_axis_tvalid && s_axis_tready;

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_fire) begin
                if (call_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tdata <= call_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hold the receiver off for a long stretch once asked
    initial begin
        wait (hold_req);
        hold_off = 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // monitor: predict on accepted input, check on accepted output
    always @(posedge i_clk) begin
        t_report got, want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got = '0;
                got.car_id = m_axis_tdata[1:0]; got.status = m_axis_tdata[3:2];
                got.car_floor = m_axis_tdata[8:4]; got.car_dir = m_axis_tdata[10:9];
                got.car_moving = m_axis_tdata[11]; got.arrived = m_axis_tdata[12];
                got.pending = m_axis_tdata[18:13]; got.last = m_axis_tlast;
                if (expected_reports.size() == 0) begin
                    report_error($sformatf("unexpected report %h", got));
                end else begin
                    want = expected_reports.pop_front();
                    if (got.car_id !== want.car_id) report_error("car_id mismatch");
                    if (got.status !== want.status) report_error("status mismatch");
                    if (got.car_floor !== want.car_floor) report_error("car_floor mismatch");
                    if (got.car_dir !== want.car_dir) report_error("car_dir mismatch");
                    if (got.car_moving !== want.car_moving) report_error("car_moving mismatch");
                    if (got.arrived !== want.arrived) report_error("arrived mismatch");
                    if (got.pending !== want.pending) report_error("pending mismatch");
                    if (got.last !== want.last) report_error("last mismatch");
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [15:0] pack_request(t_func fn, int car, int flr, bit down);
        return {6'd0, down, flr[4:0], car[1:0], fn};
    endfunction

    task automatic write_reg(input logic idx, input logic [2:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx; i_cfg_data <= val; i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_STRATEGY) strat_m = t_strat'(val[1:0]);
        else cars_m = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (call_queue.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: hall calls, car calls and ticks in random order, with an occasional raw random word.
    task automatic queue_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 40)
                enqueue(pack_request(FUNC_HALL, $urandom_range(3),
                    $urandom_range(31), $urandom_range(1)));
            else if (r < 75)
                enqueue(pack_request(FUNC_CAR, $urandom_range(3),
                    $urandom_range(17), $urandom_range(1)));
            else if (r < 97)
                enqueue(pack_request(FUNC_TICK, $urandom_range(3),
                    $urandom_range(31), $urandom_range(1)));
            else
                enqueue(16'($urandom_range(16'hFFFF)) | 16'h3);
        end
    endtask

    initial begin
        strat_m = STRAT_SCAN; cars_m = 3;
        for (int c = 0; c < CARS; c++) begin
            at_floor[c] = 1; heading[c] = DIR_IDLE; moving[c] = 0; call_cnt[c] = 0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, no such car, duplicates, floor clamps, same-floor stop
        enqueue(pack_request(FUNC_HALL, 0, 0, 0));
        enqueue(pack_request(FUNC_HALL, 0, 31, 1));
        enqueue(pack_request(FUNC_HALL, 0, 16, 1));
        enqueue(pack_request(FUNC_CAR, 0, 16, 0));
        enqueue(pack_request(FUNC_CAR, 3, 5, 0));
        enqueue(pack_request(FUNC_CAR, 1, 8, 1));
        enqueue(pack_request(FUNC_CAR, 1, 1, 0));
        enqueue(pack_request(FUNC_HALL, 2, 4, 0));
        enqueue(pack_request(FUNC_HALL, 2, 12, 1));
        enqueue(16'hFFFF);
        repeat (4) enqueue(pack_request(FUNC_TICK, 3, 31, 1));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_STRATEGY, 3'(ph % 4));
            write_reg(REG_CARS, (ph == 0) ? 3'd4 : (ph == 1) ? 3'd0 :
                      (ph == 2) ? 3'd7 : (ph == 3) ? 3'd1 : 3'($urandom_range(1, 4)));
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 47; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 47; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (ph == 4) begin
                // fill one car completely while the output is held off
                for (int f = 1; f <= 16; f++) begin
                    enqueue(pack_request(FUNC_HALL, 0, f, f % 2));
                    enqueue(pack_request(FUNC_CAR, 0, f, 0));
                end
                enqueue(pack_request(FUNC_CAR, 0, 3, 0));
                enqueue(pack_request(FUNC_TICK, 0, 0, 0));
                hold_req = 1'b1;
            end
            queue_random(29);
            drain();
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: elevator_group_scheduler.f
rtl/egs_pkg.sv
rtl/elevator_group_scheduler.sv
verif/elevator_group_scheduler_test.sv
